// ===== src/ddpe_pkg.sv =====
// Package for the differential-drive pose estimator.
// Holds payload structs, controller commands, states and the CORDIC arc table.
`timescale 1ns / 1ps
package ddpe_pkg;

  localparam int CordicSteps = 16;
  localparam int MaxSteps = 24;
  localparam int UsedSteps = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
  localparam int StepBits = $clog2(MaxSteps);

  localparam logic [31:0] CordicGain = 32'd652032875;
  localparam logic [31:0] BamPerRad = 32'd683565276;

  localparam logic [15:0] InvWheelBaseReset = 16'd13653;
  localparam logic [15:0] HeadingGainReset = 16'd32768;

  localparam logic RegInvWheelBase = 1'b0;
  localparam logic RegHeadingGain = 1'b1;

  localparam logic OpPredict = 1'b0;
  localparam logic OpCorrect = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [15:0] time_step;
    logic signed [15:0] imu_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CORDIC, S_MX1, S_MX2, S_MY1, S_MY2,
    S_T1, S_T2, S_T3, S_COMMIT, S_CORR, S_OUT
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic   load;
    logic   setup;
    logic   rotate;
    state_t phase;
    logic   commit;
    logic   correct;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic is_correct;
  } status_t;

  function automatic logic [31:0] arc(input logic [StepBits-1:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051D;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2E;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
        5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
        5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/ddpe_ctrl.sv =====
// Controller state machine for the pose estimator.
// Depends on ddpe_pkg for states, commands and status.
`timescale 1ns / 1ps
module ddpe_ctrl import ddpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.phase = state;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (status.is_correct) begin
          state_next = S_CORR;
        end else begin
          cmd.setup = 1'b1;
          state_next = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.rotate = 1'b1;
        if (status.cordic_done) state_next = S_MX1;
      end
      S_MX1: state_next = S_MX2;
      S_MX2: state_next = S_MY1;
      S_MY1: state_next = S_MY2;
      S_MY2: state_next = S_T1;
      S_T1: state_next = S_T2;
      S_T2: state_next = S_T3;
      S_T3: state_next = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_CORR: begin
        cmd.correct = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/ddpe_datapath.sv =====
// Datapath of the pose estimator: CORDIC, shared multiplier chain and state.
// Depends on ddpe_pkg for types, constants and the arc table.
`timescale 1ns / 1ps
module ddpe_datapath import ddpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output status_t   status,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data,
  output out_item_t out_item
);

  logic [15:0] inv_base, gain;
  in_item_t item;
  logic signed [31:0] x_pos, y_pos;
  logic [15:0] head, mspeed;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [StepBits-1:0] step;
  logic signed [16:0] vsum;
  logic signed [15:0] vmean;
  logic signed [47:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] dx_step, turn_step;
  logic signed [33:0] cos_v, sin_v;
  logic signed [31:0] ang;

  assign vsum = 17'(item.left_speed) + 17'(item.right_speed);
  assign vmean = vsum[16:1];
  assign cos_v = flip ? -cx : cx;
  assign sin_v = flip ? -cy : cy;
  assign ang = {head, 16'h0};
  assign status.cordic_done = (step == StepBits'(UsedSteps - 1));
  assign status.is_correct = (item.operation == OpCorrect);

  // Position step from the registered speed times cos or sin, scaled by the time step.
  assign dx_step = (64'(prod) * $signed({1'b0, item.time_step}) + (64'sd1 <<< 41)) >>> 42;
  // Turn in radians converted to whole binary-angle units.
  assign turn_step = (acc * $signed({1'b0, BamPerRad}) + (64'sd1 <<< 35)) >>> 36;

  // Saturating add of a Q16.16 position step.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [63:0] d);
    logic signed [64:0] s;
    begin
      s = 65'(a) + 65'(d);
      if (s > 65'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -65'sd2147483648) return 32'sh80000000;
      return s[31:0];
    end
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_base <= InvWheelBaseReset;
      gain <= HeadingGainReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegInvWheelBase) inv_base <= cfg_data;
      else gain <= cfg_data;
    end
  end

  // Pose state, CORDIC iteration and the multiply chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      head <= '0;
      mspeed <= '0;
    end else begin
      if (cmd.load) item <= in_item;
      if (cmd.setup) begin
        step <= '0;
        cx <= 34'(CordicGain);
        cy <= '0;
        if (ang > 32'sh40000000) begin
          cz <= 34'(ang) - 34'sh80000000; flip <= 1'b1;
        end else if (ang < -32'sh40000000) begin
          cz <= 34'(ang) + 34'sh80000000; flip <= 1'b1;
        end else begin
          cz <= 34'(ang); flip <= 1'b0;
        end
      end
      if (cmd.rotate) begin
        step <= step + 1'b1;
        if (cz >= 0) begin
          cx <= cx - (cy >>> step); cy <= cy + (cx >>> step);
          cz <= cz - 34'(arc(step));
        end else begin
          cx <= cx + (cy >>> step); cy <= cy - (cx >>> step);
          cz <= cz + 34'(arc(step));
        end
      end
      // One multiply per cycle, registered between steps.
      unique case (cmd.phase)
        S_MX1: prod <= 48'(vmean) * 48'(cos_v);
        S_MX2: x_pos <= sat_add(x_pos, dx_step);
        S_MY1: prod <= 48'(vmean) * 48'(sin_v);
        S_MY2: y_pos <= sat_add(y_pos, dx_step);
        S_T1: prod <= (48'(item.right_speed) - 48'(item.left_speed)) *
                      $signed({1'b0, inv_base});
        S_T2: acc <= (64'(prod) * $signed({1'b0, item.time_step})) >>> 16;
        S_T3: acc <= turn_step;
        default: ;
      endcase
      if (cmd.commit) begin
        head <= head + acc[15:0];
        mspeed <= vmean;
      end
      if (cmd.correct) begin
        acc <= (64'($signed(item.imu_heading - head)) * $signed({1'b0, gain}) +
                64'sd32768) >>> 16;
        head <= head + 16'(((64'($signed(item.imu_heading - head)) *
                $signed({1'b0, gain}) + 64'sd32768) >>> 16));
      end
    end
  end

  assign out_item.pos_x = x_pos;
  assign out_item.pos_y = y_pos;
  assign out_item.heading = head;
  assign out_item.speed = mspeed;

endmodule

// ===== src/diff_drive_pose_estimator.sv =====
// Differential-drive pose estimator, top level.
// Predict runs setup, a 16-step CORDIC loop, seven multiply steps and commit before the
// result is offered; correct goes from setup to a single correction step.
// Throughput is one item at a time; a new item is taken in the cycle after the result
// is accepted.
// Synchronous reset clears the pose and loads the register defaults.
`timescale 1ns / 1ps
module diff_drive_pose_estimator import ddpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  status_t status;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  // Indexes beyond the register list are dropped.
  assign cfg_write = cfg_valid && (cfg_index[1] == 1'b0);

  ddpe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  ddpe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_item(in_data),
    .cfg_valid(cfg_write), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
    .out_item(out_data)
  );

endmodule
